>>> rtl/bmc_pkg.sv
// Shared types, constants and a helper function of the branch miss cache.
package bmc_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int ADDR_W      = 64;
  localparam int CMD_W       = 3;
  localparam int LIMIT_W     = 4;
  localparam int SLOT_W      = 3;
  localparam int SEED_W      = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [LIMIT_W-1:0] LIST_MAX = LIMIT_W'(8);

  localparam logic [CMD_W-1:0] CMD_ACCESS = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_LOOKUP = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_SNAP   = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_LIST   = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(4);

  typedef enum logic [2:0] {
    OP_ACCESS,
    OP_LOOKUP,
    OP_SNAP,
    OP_LIST,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  pc;
    logic [LIMIT_W-1:0] limit;
  } job_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot_index;
    logic [ADDR_W-1:0] listed_pc;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_AGE,
    ST_WRITE,
    ST_RESULT,
    ST_COPY,
    ST_LIST,
    ST_FLUSH
  } state_e;

  // Fibonacci LFSR, taps 16, 14, 13, 11, shifting left.
  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    lfsr_step = {s[SEED_W-2:0], s[15] ^ s[13] ^ s[12] ^ s[10]};
  endfunction

endpackage

>>> rtl/bmc_fifo.sv
// Small two-entry queue used between the stages of the branch miss cache.
module bmc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import bmc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == NW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + NW'(do_push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/bmc_front.sv
// Front end: takes command beats, decodes them and queues the valid ones.
module bmc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [bmc_pkg::CMD_W-1:0]      command,
  input  logic [bmc_pkg::ADDR_W-1:0]     pc,
  input  logic [bmc_pkg::LIMIT_W-1:0]    list_limit,
  input  logic                           job_pop,
  output bmc_pkg::job_t                  job,
  output logic                           job_empty
);
  import bmc_pkg::*;

  job_t           dec;
  logic           dec_ok;
  logic           q_full;
  logic [$bits(job_t)-1:0] q_rdata;

  always_comb begin
    dec.pc    = pc;
    dec.limit = list_limit;
    dec_ok    = 1'b1;
    unique case (command)
      CMD_ACCESS: dec.op = OP_ACCESS;
      CMD_LOOKUP: dec.op = OP_LOOKUP;
      CMD_SNAP:   dec.op = OP_SNAP;
      CMD_LIST:   dec.op = OP_LIST;
      CMD_CLEAR:  dec.op = OP_CLEAR;
      default: begin
        // Codes with no meaning are taken and dropped.
        dec.op = OP_LOOKUP;
        dec_ok = 1'b0;
      end
    endcase
  end

  assign full = q_full;
  assign job  = job_t'(q_rdata);

  bmc_fifo #(
    .W ($bits(job_t))
  ) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (push && dec_ok),
    .wdata (dec),
    .full  (q_full),
    .pop   (job_pop),
    .rdata (q_rdata),
    .empty (job_empty)
  );

endmodule

>>> rtl/bmc_back.sv
// Back end: sequencer that walks the entry memories one slot per cycle unless a full result queue stalls a list.
module bmc_back #(
  parameter int ENTRIES = bmc_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  bmc_pkg::job_t job,
  input  logic          job_empty,
  output logic          job_pop,
  input  logic          res_full,
  output logic          res_push,
  output bmc_pkg::res_t res_data
);
  import bmc_pkg::*;

  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int AW   = IW;
  localparam int MW   = AW + 2;
  localparam int CMPW = (AW > LIMIT_W) ? AW : LIMIT_W;
  // Reciprocal of ENTRIES, exact for every 16-bit seed.
  localparam int RS   = SEED_W + IW;
  localparam logic [SEED_W:0] RECIP =
    (SEED_W + 1)'(((64'd1 << RS) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));

  state_e state, state_next;

  // Entry memories: address, {valid, used, age}, and the snapshot copy.
  logic [ADDR_W-1:0] addr_mem [ENTRIES];
  logic [MW-1:0]     meta_mem [ENTRIES];
  logic [ADDR_W-1:0] snap_mem [ENTRIES];

  logic [ADDR_W-1:0] rd_addr;
  logic [MW-1:0]     rd_meta;
  logic [ADDR_W-1:0] rd_snap;

  logic              addr_we, meta_we, snap_we;
  logic [IW-1:0]     addr_wa, meta_wa, snap_wa;
  logic [ADDR_W-1:0] addr_wd, snap_wd;
  logic [MW-1:0]     meta_wd;

  job_t              cur;
  logic [CW-1:0]     iss;
  logic              p_vld;
  logic [IW-1:0]     p_idx;
  logic              adv;
  logic              issuing;
  logic              proc_last;

  logic [SEED_W-1:0]   seed;
  logic                mod_ph;
  logic [2*SEED_W:0]   mod_prod;
  logic [SEED_W-1:0]   mod_q;
  logic [SEED_W-1:0]   mod_rem;
  logic [IW-1:0]       start;

  logic              hit_f, inv_f, nh_f, nl_f, lk_f;
  logic [IW-1:0]     hit_idx, inv_idx, nh_idx, nl_idx, lk_idx;
  logic [AW-1:0]     hit_age;
  logic [IW-1:0]     oldest;

  logic [IW-1:0]     pick;
  logic [AW-1:0]     pick_age;

  logic              m_valid, m_used;
  logic [AW-1:0]     m_age;
  logic              age_up;

  logic [LIMIT_W-1:0] n;
  logic [LIMIT_W-1:0] cap;
  logic               list_hit;
  logic               cap_reached;
  logic               pend_v;
  res_t               pend;

  assign m_valid   = rd_meta[MW-1];
  assign m_used    = rd_meta[MW-2];
  assign m_age     = rd_meta[AW-1:0];
  assign proc_last = p_vld && (p_idx == IW'(ENTRIES - 1));
  assign issuing   = iss < CW'(ENTRIES);

  // Seed modulo ENTRIES: quotient by reciprocal multiply, then remainder.
  assign mod_prod = (2 * SEED_W + 1)'(seed) * (2 * SEED_W + 1)'(RECIP);
  assign mod_rem  = seed - SEED_W'(mod_q * SEED_W'(ENTRIES));

  // Replacement choice: hit, else first free, else never-rehit slot found
  // circularly from the random start, else the tracked oldest slot.
  always_comb begin
    priority if (hit_f) begin
      pick = hit_idx;
    end else if (inv_f) begin
      pick = inv_idx;
    end else if (nh_f) begin
      pick = nh_idx;
    end else if (nl_f) begin
      pick = nl_idx;
    end else begin
      pick = oldest;
    end
    pick_age = hit_f ? hit_age : AW'(ENTRIES - 1);
  end

  assign age_up      = p_vld && m_valid && (m_age < pick_age);
  assign cap         = (cur.limit > LIST_MAX) ? LIST_MAX : cur.limit;
  assign list_hit    = p_vld && (CMPW'(m_age) < CMPW'(cur.limit));
  assign cap_reached = (n + 1'b1) == cap;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (iss == CW'(ENTRIES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (!job_empty) begin
          unique case (job.op)
            OP_ACCESS: state_next = ST_MOD;
            OP_LOOKUP: state_next = ST_SCAN;
            OP_SNAP:   state_next = ST_COPY;
            OP_LIST:   state_next = ST_LIST;
            OP_CLEAR:  state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_ph) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (proc_last) state_next = (cur.op == OP_ACCESS) ? ST_AGE : ST_RESULT;
      end
      ST_AGE: begin
        if (proc_last) state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_RESULT;
      ST_RESULT: begin
        if (!res_full) state_next = ST_IDLE;
      end
      ST_COPY: begin
        if (proc_last) state_next = ST_IDLE;
      end
      ST_LIST: begin
        if (adv && list_hit && cap_reached) begin
          state_next = ST_FLUSH;
        end else if (adv && proc_last) begin
          state_next = (pend_v || list_hit) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!res_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and memory write controls.
  always_comb begin
    job_pop  = 1'b0;
    adv      = 1'b1;
    res_push = 1'b0;
    res_data = '0;
    addr_we  = 1'b0;
    addr_wa  = p_idx;
    addr_wd  = '0;
    meta_we  = 1'b0;
    meta_wa  = p_idx;
    meta_wd  = rd_meta;
    snap_we  = 1'b0;
    snap_wa  = p_idx;
    snap_wd  = rd_addr;
    unique case (state)
      ST_CLEAR: begin
        addr_we = 1'b1;
        addr_wa = IW'(iss);
        meta_we = 1'b1;
        meta_wa = IW'(iss);
        meta_wd = {2'b00, AW'(iss)};
        snap_we = 1'b1;
        snap_wa = IW'(iss);
        snap_wd = '0;
      end
      ST_IDLE: job_pop = !job_empty;
      ST_AGE: begin
        meta_we = age_up;
        meta_wd = {m_valid, m_used, m_age + 1'b1};
      end
      ST_WRITE: begin
        addr_we = 1'b1;
        addr_wa = pick;
        addr_wd = cur.pc;
        meta_we = 1'b1;
        meta_wa = pick;
        meta_wd = {1'b1, hit_f, AW'(0)};
      end
      ST_RESULT: begin
        res_push            = !res_full;
        res_data.found      = lk_f;
        res_data.slot_index = SLOT_W'(lk_idx);
      end
      ST_COPY: snap_we = p_vld;
      ST_LIST: begin
        // An earlier pending beat must leave before a new one takes its place.
        adv      = !(list_hit && pend_v && res_full);
        res_push = list_hit && pend_v && !res_full;
        res_data = pend;
      end
      ST_FLUSH: begin
        res_push      = !res_full;
        res_data      = pend;
        res_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (addr_we) addr_mem[addr_wa] <= addr_wd;
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (snap_we) snap_mem[snap_wa] <= snap_wd;
    if (adv && issuing) begin
      rd_addr <= addr_mem[IW'(iss)];
      rd_meta <= meta_mem[IW'(iss)];
      rd_snap <= snap_mem[IW'(iss)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      iss    <= '0;
      p_vld  <= 1'b0;
      seed   <= SEED_W'(1);
      oldest <= IW'(ENTRIES - 1);
      pend_v <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: begin
          iss    <= iss + 1'b1;
          oldest <= IW'(ENTRIES - 1);
        end
        ST_IDLE: begin
          iss     <= '0;
          p_vld   <= 1'b0;
          hit_f   <= 1'b0;
          inv_f   <= 1'b0;
          nh_f    <= 1'b0;
          nl_f    <= 1'b0;
          lk_f    <= 1'b0;
          lk_idx  <= '0;
          n       <= '0;
          pend_v  <= 1'b0;
          mod_ph  <= 1'b0;
          if (!job_empty) begin
            cur <= job;
            if (job.op == OP_ACCESS) seed <= lfsr_step(seed);
          end
        end
        ST_MOD: begin
          if (!mod_ph) begin
            mod_q  <= SEED_W'(mod_prod >> RS);
            mod_ph <= 1'b1;
          end else begin
            start <= IW'(mod_rem);
          end
        end
        ST_SCAN, ST_AGE, ST_COPY, ST_LIST: begin
          // After the last slot issuing is already off, so p_vld drops here.
          if (adv) begin
            p_vld <= issuing;
            p_idx <= IW'(iss);
            if (issuing) iss <= iss + 1'b1;
          end
          if (proc_last && (state_next != state)) begin
            iss <= '0;
          end
          if (state == ST_SCAN && p_vld) begin
            if (!hit_f && m_valid && rd_addr == cur.pc) begin
              hit_f   <= 1'b1;
              hit_idx <= p_idx;
              hit_age <= m_age;
            end
            if (!inv_f && !m_valid) begin
              inv_f   <= 1'b1;
              inv_idx <= p_idx;
            end
            if (m_valid && !m_used) begin
              if (!nl_f) begin
                nl_f   <= 1'b1;
                nl_idx <= p_idx;
              end
              if (!nh_f && p_idx >= start) begin
                nh_f   <= 1'b1;
                nh_idx <= p_idx;
              end
            end
            if (!lk_f && rd_snap == cur.pc) begin
              lk_f   <= 1'b1;
              lk_idx <= p_idx;
            end
          end
          if (state == ST_AGE && age_up && (m_age + 1'b1) == AW'(ENTRIES - 1)) begin
            oldest <= p_idx;
          end
          if (state == ST_LIST && adv && list_hit) begin
            pend_v          <= 1'b1;
            pend.found      <= m_valid;
            pend.slot_index <= SLOT_W'(p_idx);
            pend.listed_pc  <= rd_addr;
            pend.last       <= 1'b0;
            n               <= n + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/branch_miss_cache_nru.sv
// Top level of the branch miss cache with not-recently-used replacement.
//
//   channel   direction  handshake        fields
//   command   in         push / full      command, pc, list_limit
//   result    out        pop / empty      found, slot_index, listed_pc, last
//
// A lookup makes one pass over the entries. An access first reduces the
// random seed modulo ENTRIES by a reciprocal multiply, then one pass finds
// the slot and a second pass ages the entries, one slot per cycle.
// Snapshot, clear and list each walk the entries; a list stops once its limit is reached.
// After reset a clearing pass over all entries runs before the first command
// is taken; a full result queue stalls the back end, the command queue the front.
module branch_miss_cache_nru #(
  parameter int ENTRIES = bmc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [bmc_pkg::CMD_W-1:0]     command,
  input  logic [bmc_pkg::ADDR_W-1:0]    pc,
  input  logic [bmc_pkg::LIMIT_W-1:0]   list_limit,
  output logic                          empty,
  input  logic                          pop,
  output logic                          found,
  output logic [bmc_pkg::SLOT_W-1:0]    slot_index,
  output logic [bmc_pkg::ADDR_W-1:0]    listed_pc,
  output logic                          last
);
  import bmc_pkg::*;

  job_t  job;
  logic  job_empty;
  logic  job_pop;
  logic  res_full;
  logic  res_push;
  res_t  res_in;
  res_t  res_out;
  logic [$bits(res_t)-1:0] res_rdata;

  // Front end decodes each command beat and parks it in a short queue.
  bmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .pc         (pc),
    .list_limit (list_limit),
    .job_pop    (job_pop),
    .job        (job),
    .job_empty  (job_empty)
  );

  // Back end walks the entries and produces result beats.
  bmc_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // Result queue decouples the back end from the consumer.
  bmc_fifo #(
    .W ($bits(res_t))
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out    = res_t'(res_rdata);
  assign found      = res_out.found;
  assign slot_index = res_out.slot_index;
  assign listed_pc  = res_out.listed_pc;
  assign last       = res_out.last;

`ifndef ASSERT_OFF
  // The back end must never hand a result to a full queue.
  a_no_res_overflow : assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result beat pushed into a full queue");

  // A command is only taken from the queue when one is waiting.
  a_no_job_underflow : assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("command popped from an empty queue");

  // The back end does not start a command in the cycle it emits a result.
  a_pop_push_apart : assert property (@(posedge clk) disable iff (rst)
    (job_pop && !job_empty) |-> !res_push)
    else $error("command started while a result beat was leaving");
`endif

endmodule
